[sv/assert_macros.svh]
// Assertion macros shared by the signed floored modulo RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SFM_ASSERT_NOW(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication.
`define SFM_ASSERT_NEXT(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

[sv/sfm_pkg.sv]
// ----------------------------------------------------------------------------
// sfm_pkg
// Types, width codes and helpers for the signed floored modulo pipeline.
// ----------------------------------------------------------------------------
package sfm_pkg;

	localparam int DATA_W  = 64;
	localparam int OP_W    = 2;
	// One quotient bit is retired per divider stage.
	localparam int STEPS   = DATA_W;

	localparam logic [OP_W-1:0] OP_W32 = 2'd0;
	localparam logic [OP_W-1:0] OP_W46 = 2'd1;
	localparam logic [OP_W-1:0] OP_W64 = 2'd2;

	typedef logic [DATA_W-1:0] word_t;

	// Sign and divisor information that rides along with the division.
	typedef struct packed {
		logic  a_neg;
		logic  p_neg;
		logic  zero;
		word_t p;
	} side_t;

	function automatic word_t sext32(input word_t v);
		sext32 = {{(DATA_W-32){v[31]}}, v[31:0]};
	endfunction

	function automatic word_t sext46(input word_t v);
		sext46 = {{(DATA_W-46){v[45]}}, v[45:0]};
	endfunction

endpackage

[sv/sfm_req_if.sv]
// ----------------------------------------------------------------------------
// sfm_req_if
// Request channel: width code, dividend and divisor with valid/ready.
// ----------------------------------------------------------------------------
interface sfm_req_if;
	logic                         valid;
	logic                         ready;
	logic [sfm_pkg::OP_W-1:0]     op;
	logic signed [sfm_pkg::DATA_W-1:0] dividend;
	logic signed [sfm_pkg::DATA_W-1:0] divisor;

	modport source (output valid, op, dividend, divisor, input ready);
	modport sink (input valid, op, dividend, divisor, output ready);
endinterface

[sv/sfm_rsp_if.sv]
// ----------------------------------------------------------------------------
// sfm_rsp_if
// Response channel: floored remainder and zero divisor flag with valid/ready.
// ----------------------------------------------------------------------------
interface sfm_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [sfm_pkg::DATA_W-1:0] remainder;
	logic                              zero_divisor;

	modport source (output valid, remainder, zero_divisor, input ready);
	modport sink (input valid, remainder, zero_divisor, output ready);
endinterface

[sv/sfm_pre.sv]
// ----------------------------------------------------------------------------
// sfm_pre
// Entry stage: sign extension by width code, operand magnitudes, zero check.
// ----------------------------------------------------------------------------
module sfm_pre (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid,
	input  logic [sfm_pkg::OP_W-1:0]  op,
	input  sfm_pkg::word_t            dividend,
	input  sfm_pkg::word_t            divisor,
	output logic                      valid_s1,
	output sfm_pkg::word_t            num_s1,
	output sfm_pkg::word_t            den_s1,
	output sfm_pkg::side_t            side_s1
);

	sfm_pkg::word_t a_ext;
	sfm_pkg::word_t p_ext;

	always_comb begin
		unique case (op)
			sfm_pkg::OP_W32: begin
				a_ext = sfm_pkg::sext32(dividend);
				p_ext = sfm_pkg::sext32(divisor);
			end
			sfm_pkg::OP_W46: begin
				a_ext = sfm_pkg::sext46(dividend);
				p_ext = sfm_pkg::sext46(divisor);
			end
			default: begin
				// The unused code behaves as the full width.
				a_ext = dividend;
				p_ext = divisor;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1        <= a_ext[sfm_pkg::DATA_W-1] ? -a_ext : a_ext;
			den_s1        <= p_ext[sfm_pkg::DATA_W-1] ? -p_ext : p_ext;
			side_s1.a_neg <= a_ext[sfm_pkg::DATA_W-1];
			side_s1.p_neg <= p_ext[sfm_pkg::DATA_W-1];
			side_s1.zero  <= (p_ext == '0);
			side_s1.p     <= p_ext;
		end
	end

endmodule

[sv/sfm_div_step.sv]
// ----------------------------------------------------------------------------
// sfm_div_step
// One restoring division step on unsigned magnitudes, one register stage.
// ----------------------------------------------------------------------------
module sfm_div_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid,
	input  sfm_pkg::word_t  rem,
	input  sfm_pkg::word_t  num,
	input  sfm_pkg::word_t  den,
	input  sfm_pkg::side_t  side,
	output logic            valid_sn,
	output sfm_pkg::word_t  rem_sn,
	output sfm_pkg::word_t  num_sn,
	output sfm_pkg::word_t  den_sn,
	output sfm_pkg::side_t  side_sn
);

	logic [sfm_pkg::DATA_W:0] trial;
	logic [sfm_pkg::DATA_W:0] diff;
	sfm_pkg::word_t           rem_next;

	// The partial remainder stays below the divisor, so a successful
	// subtraction always fits back into one word.
	always_comb begin
		trial    = {rem, num[sfm_pkg::DATA_W-1]};
		diff     = trial - {1'b0, den};
		rem_next = diff[sfm_pkg::DATA_W] ? trial[sfm_pkg::DATA_W-1:0]
		                                 : diff[sfm_pkg::DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sn  <= rem_next;
			num_sn  <= {num[sfm_pkg::DATA_W-2:0], 1'b0};
			den_sn  <= den;
			side_sn <= side;
		end
	end

endmodule

[sv/sfm_post.sv]
// ----------------------------------------------------------------------------
// sfm_post
// Exit stage: sign fix-up into the floored range and the output register.
// ----------------------------------------------------------------------------
module sfm_post (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid,
	input  sfm_pkg::word_t  rem,
	input  sfm_pkg::side_t  side,
	output logic            valid_s66,
	output sfm_pkg::word_t  remainder_s66,
	output logic            zero_s66
);

	sfm_pkg::word_t x;
	sfm_pkg::word_t y;
	sfm_pkg::word_t fixed;

	// Negating the remainder and adding the divisor share one adder:
	// a negative dividend inverts the remainder and feeds the carry in.
	always_comb begin
		x     = side.a_neg ? ~rem : rem;
		y     = (side.a_neg != side.p_neg) ? side.p : '0;
		fixed = x + y + {{(sfm_pkg::DATA_W-1){1'b0}}, side.a_neg};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s66 <= 1'b0;
		end else if (en) begin
			valid_s66 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			remainder_s66 <= (side.zero || rem == '0) ? '0 : fixed;
			zero_s66      <= side.zero;
		end
	end

endmodule

[sv/signed_floored_modulo.sv]
// ----------------------------------------------------------------------------
// signed_floored_modulo
// Pipelined signed floored modulo for 32, 46 and 64 bit operands.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   req      in         op, dividend, divisor
//   rsp      out        remainder, zero_divisor
//
// One transaction is accepted per cycle unless rsp stalls. The pipeline is made of
// the 64 restoring division stages, one quotient bit each, plus an entry stage
// and an exit stage.
// A stall on rsp freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_floored_modulo (
	input  logic       clk,
	input  logic       arst_n,
	sfm_req_if.sink    req,
	sfm_rsp_if.source  rsp
);

	localparam int STEPS = sfm_pkg::STEPS;

	logic           adv;
	logic           v_c    [0:STEPS];
	sfm_pkg::word_t rem_c  [0:STEPS];
	sfm_pkg::word_t num_c  [0:STEPS];
	sfm_pkg::word_t den_c  [0:STEPS];
	sfm_pkg::side_t side_c [0:STEPS];
	sfm_pkg::word_t remainder_s66;
	logic           valid_s66;
	logic           zero_s66;

	// The output register is the last stage, so the pipe moves whenever
	// that register is empty or being drained.
	assign adv       = !valid_s66 || rsp.ready;
	assign req.ready = adv;
	assign rem_c[0]  = '0;

	sfm_pre u_pre (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid    (req.valid),
		.op       (req.op),
		.dividend (req.dividend),
		.divisor  (req.divisor),
		.valid_s1 (v_c[0]),
		.num_s1   (num_c[0]),
		.den_s1   (den_c[0]),
		.side_s1  (side_c[0])
	);

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		sfm_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.valid    (v_c[i]),
			.rem      (rem_c[i]),
			.num      (num_c[i]),
			.den      (den_c[i]),
			.side     (side_c[i]),
			.valid_sn (v_c[i+1]),
			.rem_sn   (rem_c[i+1]),
			.num_sn   (num_c[i+1]),
			.den_sn   (den_c[i+1]),
			.side_sn  (side_c[i+1])
		);
	end

	sfm_post u_post (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.valid         (v_c[STEPS]),
		.rem           (rem_c[STEPS]),
		.side          (side_c[STEPS]),
		.valid_s66     (valid_s66),
		.remainder_s66 (remainder_s66),
		.zero_s66      (zero_s66)
	);

	assign rsp.valid        = valid_s66;
	assign rsp.remainder    = remainder_s66;
	assign rsp.zero_divisor = zero_s66;

	`SFM_ASSERT_NOW(a_zero_result, rsp.valid && rsp.zero_divisor, rsp.remainder == '0, "zero divisor with nonzero remainder")
	`SFM_ASSERT_NEXT(a_sign_follows_divisor, adv && v_c[STEPS] && !side_c[STEPS].zero, rsp.remainder == '0 || rsp.remainder[sfm_pkg::DATA_W-1] == $past(side_c[STEPS].p_neg), "remainder sign differs from divisor sign")
	`SFM_ASSERT_NEXT(a_stall_holds_entry, !adv, $stable(v_c[0]) && $stable(num_c[0]), "entry stage changed during a stall")
	`SFM_ASSERT_NEXT(a_remainder_below_divisor, adv && v_c[STEPS], rem_c[STEPS] < den_c[STEPS] || den_c[STEPS] == '0 || !v_c[STEPS], "partial remainder not below divisor")

endmodule

[dv/signed_floored_modulo_tb.sv]
// ----------------------------------------------------------------------------
// signed_floored_modulo_tb
// Self-checking bench for the floored modulo pipeline. A directed set of
// corner operands is followed by random operand pairs in all width codes.
// Both channels idle at random, and every result is compared with a
// prediction.
// ----------------------------------------------------------------------------

class modulo_scoreboard;
	typedef struct {
		logic [sfm_pkg::OP_W-1:0] op;
		sfm_pkg::word_t           dividend;
		sfm_pkg::word_t           divisor;
		sfm_pkg::word_t           remainder;
		logic                     zero_divisor;
	} residue_t;

	residue_t    expected_q[$];
	int unsigned mismatches = 0;

	// Keeps the low w bits and copies bit w-1 upward.
	static function sfm_pkg::word_t widen(sfm_pkg::word_t v, int unsigned w);
		logic signed [sfm_pkg::DATA_W-1:0] s;
		s = v;
		s = (s <<< (sfm_pkg::DATA_W - w)) >>> (sfm_pkg::DATA_W - w);
		return s;
	endfunction

	static function residue_t floored_mod(logic [sfm_pkg::OP_W-1:0] op,
			sfm_pkg::word_t dividend, sfm_pkg::word_t divisor);
		residue_t       res;
		int unsigned    w;
		sfm_pkg::word_t a, p, mag_a, mag_p, r;
		case (op)
			sfm_pkg::OP_W32: w = 32;
			sfm_pkg::OP_W46: w = 46;
			default: w = 64;
		endcase
		a = widen(dividend, w);
		p = widen(divisor, w);
		res.op = op;
		res.dividend = dividend;
		res.divisor = divisor;
		res.remainder = '0;
		res.zero_divisor = 1'b0;
		if (p == '0) begin
			res.zero_divisor = 1'b1;
			return res;
		end
		mag_a = a[63] ? -a : a;
		mag_p = p[63] ? -p : p;
		r = mag_a % mag_p;
		if (r != '0) begin
			if (a[63])
				r = -r;
			// A remainder on the other side of zero from the divisor is folded back.
			if (a[63] != p[63])
				r = r + p;
		end
		res.remainder = r;
		return res;
	endfunction

	function void note_request(logic [sfm_pkg::OP_W-1:0] op, sfm_pkg::word_t dividend,
			sfm_pkg::word_t divisor);
		expected_q.push_back(floored_mod(op, dividend, divisor));
	endfunction

	task report(string msg);
		mismatches++;
		$display("ERROR: %s", msg);
	endtask

	task check_response(sfm_pkg::word_t remainder, logic zero_divisor);
		residue_t want;
		if (expected_q.size() == 0) begin
			report($sformatf("result %h with no transaction outstanding", remainder));
			return;
		end
		want = expected_q.pop_front();
		if (remainder !== want.remainder)
			report($sformatf("op %0d %h mod %h: remainder %h, expected %h", want.op,
				want.dividend, want.divisor, remainder, want.remainder));
		if (zero_divisor !== want.zero_divisor)
			report($sformatf("op %0d %h mod %h: zero_divisor %b, expected %b", want.op,
				want.dividend, want.divisor, zero_divisor, want.zero_divisor));
	endtask
endclass

module signed_floored_modulo_tb;
	import sfm_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1400;
	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	bit          no_idle = 1'b0;
	int unsigned cycle_count = 0;

	modulo_scoreboard residues = new;

	sfm_req_if req_ch();
	sfm_rsp_if rsp_ch();

	signed_floored_modulo DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int unsigned draw_wait();
		if (no_idle || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic word_t rand_operand();
		word_t v;
		case ($urandom_range(0, 7))
			2: v = word_t'(longint'($urandom_range(0, 64)) - 64'sd32);
			3: begin
				v = {$urandom, $urandom} >> $urandom_range(0, 63);
				if ($urandom_range(0, 1))
					v = -v;
			end
			4: case ($urandom_range(0, 5))
				0: v = 64'h8000_0000_0000_0000;
				1: v = 64'h7FFF_FFFF_FFFF_FFFF;
				2: v = {$urandom, 32'h8000_0000};
				3: v = {$urandom, 32'h7FFF_FFFF};
				4: v = {18'($urandom_range(0, 262143)), 46'h2000_0000_0000};
				default: v = '1;
			endcase
			5: v = $urandom_range(0, 1) ? {$urandom, 32'h0} : '0;
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// Offers one transaction after a random gap and returns at the edge that takes it.
	task automatic send_request(logic [OP_W-1:0] op, word_t dividend, word_t divisor);
		int unsigned gap;
		gap = draw_wait();
		if (gap > 0) begin
			@(negedge clk) req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.dividend <= dividend;
		req_ch.divisor <= divisor;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		residues.note_request(op, dividend, divisor);
	endtask

	// Result side: random stalls, then ready held until one transaction completes.
	initial begin
		int unsigned stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				@(negedge clk) rsp_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(rsp_ch.valid && rsp_ch.ready))
				@(posedge clk);
		end
	end

	always @(posedge clk)
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			residues.check_response(rsp_ch.remainder, rsp_ch.zero_divisor);

	initial begin
		int unsigned idx;
		req_ch.valid = 1'b0;
		req_ch.op = OP_W32;
		req_ch.dividend = '0;
		req_ch.divisor = '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Sign combinations, exact multiples and zero dividends in 32-bit mode.
		send_request(OP_W32, 64'd7, 64'd3);
		send_request(OP_W32, -64'sd7, 64'd3);
		send_request(OP_W32, 64'd7, -64'sd3);
		send_request(OP_W32, -64'sd7, -64'sd3);
		send_request(OP_W32, 64'd6, -64'sd3);
		send_request(OP_W32, 64'd0, -64'sd5);
		send_request(OP_W32, 64'hDEAD_BEEF_0000_0005, 64'h1234_5678_0000_0000);
		send_request(OP_W32, 64'hFFFF_0000_8000_0000, 64'h0000_0001_FFFF_FFFF);
		send_request(OP_W32, 64'h0000_0000_7FFF_FFFF, 64'hFFFF_FFFF_8000_0000);
		send_request(OP_W32, 64'h8000_0000_8000_0000, 64'h0000_0000_7FFF_FFFF);
		// 46-bit mode: bits above the width must not reach the result.
		send_request(OP_W46, 64'h0000_2000_0000_0000, '1);
		send_request(OP_W46, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_C000_0000_0000);
		send_request(OP_W46, 64'hFFFF_DFFF_FFFF_FFFF, 64'h0000_2000_0000_0000);
		send_request(OP_W46, 64'h0000_1FFF_FFFF_FFFF, -64'sd1000);
		send_request(OP_W46, -64'sd123456789, 64'd1000);
		// 64-bit mode and the spare width code.
		send_request(OP_W64, 64'h8000_0000_0000_0000, '1);
		send_request(OP_W64, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
		send_request(OP_W64, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(OP_W64, '1, 64'h8000_0000_0000_0000);
		send_request(OP_W64, 64'h7FFF_FFFF_FFFF_FFFF, '0);
		send_request(OP_W64, 64'h8000_0000_0000_0000, 64'd1);
		send_request(OP_SPARE, -64'sd13, 64'd5);
		send_request(OP_SPARE, 64'h8000_0000_0000_0000, '1);
		send_request(OP_SPARE, 64'hFFFF_FFFF_0000_0000, 64'h0000_0001_0000_0000);

		for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
			no_idle = ((idx / 120) % 4 == 2);
			send_request(OP_W'($urandom_range(0, 3)), rand_operand(), rand_operand());
		end
		no_idle = 1'b0;
		@(negedge clk) req_ch.valid <= 1'b0;

		while (residues.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (residues.expected_q.size() != 0)
			residues.report($sformatf("%0d results never arrived",
				residues.expected_q.size()));

		if (residues.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

[files.f]
+incdir+sv
sv/sfm_pkg.sv
sv/sfm_req_if.sv
sv/sfm_rsp_if.sv
sv/sfm_pre.sv
sv/sfm_div_step.sv
sv/sfm_post.sv
sv/signed_floored_modulo.sv
dv/signed_floored_modulo_tb.sv
